### hdl/sha_pkg.sv
`default_nettype none
package sha_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned NumRounds = 64;

    localparam t_word IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [NumRounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PadByte = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        t_word      digest_word;
        logic [2:0] word_index;
        logic       last_word;
    } t_out;

    function automatic t_word ror(input t_word x, input int unsigned n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

### hdl/sha_if.sv
`default_nettype none
interface sha_in_if import sha_pkg::*; ();
    logic valid;
    logic ready;
    t_in  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if import sha_pkg::*; ();
    logic valid;
    logic ready;
    t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hdl/sha256_stream_hash.sv
// a byte that fills no block leaves the block idle; a block-filling byte runs a compression
// (64 rounds of the shared round unit, then the feed-forward add, then back to idle)
// end of message: 1 or 2 padded compressions, then the 8 digest words, each held until taken
// one request at a time; the block is not ready while compressing, padding or emitting
// reset: synchronous active low; chaining words return to the initial vector, counts clear
`default_nettype none
module sha256_stream_hash import sha_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    sha_in_if.sink  i_req,
    sha_out_if.source o_dig
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROUND = 5'b00010,
        S_ADD   = 5'b00100,
        S_PAD   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    t_word       r_h [8];
    t_word       r_v [8];
    t_word       r_w [16];
    logic [5:0]  r_rnd;
    logic        r_fin;
    logic        r_len2;
    logic [1:0]  r_pad_blk;
    logic [2:0]  r_oidx;

    logic  acc;
    t_word s0, s1, wnew, big1, big0, ch, maj, p, q;
    t_word pad_words [16];

    assign acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign s0 = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1 = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
    assign wnew = r_w[0] + s0 + r_w[9] + s1;
    assign big1 = ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25);
    assign ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign p = r_v[7] + big1 + ch + RoundK[r_rnd] + r_w[0];
    assign big0 = ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign q = big0 + maj;

    // padded block words built from the buffered bytes
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            for (int b = 0; b < 4; b++) begin
                logic [6:0] pos;
                logic [7:0] byt;
                pos = 7'(r_pad_blk[0] * 64 + i * 4 + b);
                if (pos < {1'b0, r_fill}) byt = r_w[i][31-8*b -: 8];
                else if (pos == {1'b0, r_fill}) byt = PadByte;
                else byt = 8'h00;
                if (pos[6] == r_len2 && pos[5:0] >= 6'd56 && (pos[6] || !r_pad_blk[0]))
                    byt = r_bits[8*(63 - pos[5:0]) +: 8];
                if (r_pad_blk[0] && pos[6] == 1'b0) byt = 8'h00;
                pad_words[i][31-8*b -: 8] = byt;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (acc) begin
                if (i_req.payload.byte_present && r_fill == 6'd63) n_state = S_ROUND;
                else if (i_req.payload.end_of_message) n_state = S_PAD;
            end
            S_ROUND: if (r_rnd == 6'd63) n_state = S_ADD;
            S_ADD: begin
                if (r_fin && r_pad_blk == 2'd1 && r_len2) n_state = S_PAD;
                else if (r_fin && r_pad_blk != 2'd0) n_state = S_OUT;
                else if (r_fin) n_state = S_PAD;
                else n_state = S_IDLE;
            end
            S_PAD: n_state = S_ROUND;
            S_OUT: if (o_dig.ready && r_oidx == 3'd7) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_bits <= '0;
            r_fin <= 1'b0;
            r_len2 <= 1'b0;
            r_pad_blk <= '0;
            r_oidx <= '0;
            r_rnd <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (acc) begin
                    r_fin <= i_req.payload.end_of_message;
                    r_pad_blk <= '0;
                    r_rnd <= '0;
                    if (i_req.payload.byte_present) begin
                        r_w[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <=
                            i_req.payload.data_byte;
                        r_fill <= r_fill + 6'd1;
                        r_bits <= r_bits + 64'd8;
                        r_len2 <= (r_fill + 6'd1) >= 6'd56 && r_fill != 6'd63;
                    end else begin
                        r_len2 <= r_fill >= 6'd56;
                    end
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                end
                S_ROUND: begin
                    r_rnd <= r_rnd + 6'd1;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= wnew;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + p;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= p + q;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_oidx <= '0;
                end
                S_PAD: begin
                    r_rnd <= '0;
                    r_pad_blk <= r_pad_blk + 2'd1;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    for (int i = 0; i < 16; i++) r_w[i] <= pad_words[i];
                end
                S_OUT: if (o_dig.ready) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
                        r_fill <= '0;
                        r_bits <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_dig.valid = (r_state == S_OUT);
    assign o_dig.payload.digest_word = r_h[r_oidx];
    assign o_dig.payload.word_index = r_oidx;
    assign o_dig.payload.last_word = (r_oidx == 3'd7);

    // pad pass index select: first pad block reads bytes 0..63, second reads 64..127
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready) else $error("ready while busy");
    a_out_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dig.valid && o_dig.ready && r_oidx != 3'd7) |=> (r_state == S_OUT))
        else $error("digest cut short");
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_rnd == 6'd63) |=> (r_state == S_ADD))
        else $error("round count slip");

endmodule
`default_nettype wire

### verif/sha256_stream_hash_test.sv
`timescale 1ns / 100ps
`default_nettype none
module sha256_stream_hash_test;
    import sha_pkg::*;

    typedef logic [7:0] t_byte;

    class digest_board;
        t_word  chain [8];
        t_byte  blk [64];
        int     fill;
        logic [63:0] nbits;
        t_out   pending [$];
        int     errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = IV[i];
            fill = 0;
            nbits = '0;
        endfunction

        function t_word rotr(t_word x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress(t_byte b [64]);
            t_word w [64];
            t_word v [8];
            t_word s0, s1, p, q, ch, mj;
            for (int t = 0; t < 16; t++)
                w[t] = {b[4*t], b[4*t+1], b[4*t+2], b[4*t+3]};
            for (int t = 16; t < 64; t++) begin
                s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
                s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = w[t-16] + s0 + w[t-7] + s1;
            end
            v = chain;
            for (int t = 0; t < 64; t++) begin
                s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
                ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
                p = v[7] + s1 + ch + RoundK[t] + w[t];
                s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
                mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
                q = s0 + mj;
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + p;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = p + q;
            end
            for (int i = 0; i < 8; i++) chain[i] += v[i];
        endfunction

        function void note_request(t_in r);
            t_byte a [64];
            t_byte c [64];
            logic [7:0] tail;
            t_out o;
            if (r.byte_present) begin
                blk[fill] = r.data_byte;
                fill++;
                nbits += 64'd8;
                if (fill == 64) begin
                    compress(blk);
                    fill = 0;
                end
            end
            if (!r.end_of_message) return;
            for (int i = 0; i < 64; i++) begin
                a[i] = (i < fill) ? blk[i] : 8'h00;
                c[i] = 8'h00;
            end
            a[fill] = PadByte;
            for (int i = 0; i < 8; i++) begin
                tail = nbits[8*i +: 8];
                if (fill < 56) a[63-i] = tail;
                else c[63-i] = tail;
            end
            compress(a);
            if (fill >= 56) compress(c);
            for (int i = 0; i < 8; i++) begin
                o.digest_word = chain[i];
                o.word_index = 3'(i);
                o.last_word = (i == 7);
                pending = {pending, o};
            end
            restart();
        endfunction

        function void check_word(t_out got);
            t_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected digest word %h", $realtime, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.digest_word !== e.digest_word) begin
                $display("%0t: digest_word expected %h actual %h",
                         $realtime, e.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== e.word_index) begin
                $display("%0t: word_index expected %0d actual %0d",
                         $realtime, e.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== e.last_word) begin
                $display("%0t: last_word expected %0d actual %0d",
                         $realtime, e.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    sha_in_if  req_if ();
    sha_out_if dig_if ();
    digest_board board = new();
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int sent = 0;

    sha256_stream_hash dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_dig   (dig_if.source)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        req_if.valid = 1'b0;
        req_if.payload = '0;
        dig_if.ready = 1'b0;
    end

    // receiver stall pattern, switching at random between modes
    always @(negedge i_clk) begin
        if (!i_rst_n) dig_if.ready <= 1'b0;
        else begin
            case (stall_mode)
                0: dig_if.ready <= 1'b1;
                1: dig_if.ready <= ($urandom_range(0, 3) != 0);
                2: dig_if.ready <= ($urandom_range(0, 1) == 0);
                default: dig_if.ready <= ($urandom_range(0, 9) == 0);
            endcase
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && dig_if.valid && dig_if.ready) board.check_word(dig_if.payload);
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (dig_if.valid && dig_if.ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(t_byte b, logic present, logic eom);
        t_in r;
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        r.data_byte = b;
        r.byte_present = present;
        r.end_of_message = eom;
        req_if.payload = r;
        req_if.valid = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        board.note_request(r);
        sent++;
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    task automatic send_message(int len, int mode);
        t_byte b;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: b = 8'h00;
                1: b = 8'hff;
                default: b = t_byte'($urandom);
            endcase
            if ($urandom_range(0, 9) == 0) send_request(t_byte'($urandom), 1'b0, 1'b0);
            send_request(b, 1'b1, (i == len - 1));
        end
    endtask

    task automatic wait_drained();
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int len;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'ha5, 1'b0, 1'b1);
        send_message(1, 0);
        send_message(1, 1);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        send_message(3, 2);
        send_request(8'h00, 1'b0, 1'b1);
        wait_drained();

        while (sent < 330) begin
            case ($urandom_range(0, 5))
                0: len = $urandom_range(54, 57);
                1: len = $urandom_range(62, 66);
                2: len = $urandom_range(119, 121);
                default: len = $urandom_range(1, 30);
            endcase
            send_message(len, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : 2);
            if ($urandom_range(0, 5) == 0) send_request(t_byte'($urandom), 1'b0, 1'b1);
            if ($urandom_range(0, 3) == 0) wait_drained();
        end

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
